>>> src/contact_manifold_face_clip_macros.svh
// Assertion macros shared by the contact clipping modules.
`ifndef CONTACT_MANIFOLD_FACE_CLIP_MACROS_SVH
`define CONTACT_MANIFOLD_FACE_CLIP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CMFC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CMFC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cmfc_pkg.sv
// Types, constants and helper functions of the face clipping block.
`default_nettype none
package cmfc_pkg;

  localparam int VEC_W      = 64;
  localparam int HALF_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int DIV_STEPS  = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [32:0] SAT_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] SAT_MIN = -33'sh0_7FFF_FFFF;

  typedef logic signed [HALF_W-1:0] comp_t;

  typedef struct packed {
    comp_t sx;
    comp_t sy;
    comp_t ex;
    comp_t ey;
    comp_t nx;
    comp_t ny;
  } face_t;

  // One classified word handed from the front part to the back part.
  typedef struct packed {
    face_t              ref_f;
    comp_t              inc_sx;
    comp_t              inc_sy;
    comp_t              inc_ex;
    comp_t              inc_ey;
    logic [VEC_W-1:0]   normal;
    logic signed [31:0] depth;
    logic               ref_is_b;
  } job_t;

  typedef enum logic [1:0] {
    FAULT_NONE     = 2'd0,
    FAULT_ZERO_DIV = 2'd1,
    FAULT_CLIPPED  = 2'd2
  } fault_e;

  // Difference saturated to the symmetric 32-bit range.
  function automatic comp_t sdiff(input comp_t a, input comp_t b);
    logic signed [32:0] d;
    d = {a[HALF_W-1], a} - {b[HALF_W-1], b};
    if (d > SAT_MAX) begin
      sdiff = SAT_MAX[HALF_W-1:0];
    end else if (d < SAT_MIN) begin
      sdiff = SAT_MIN[HALF_W-1:0];
    end else begin
      sdiff = d[HALF_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

>>> src/cmfc_if.sv
// Input and output channel interfaces of the face clipping block.
`default_nettype none
interface cmfc_in_if;
  logic               valid;
  logic               ready;
  logic [63:0]        face_a_start;
  logic [63:0]        face_a_end;
  logic [63:0]        face_a_dir;
  logic [63:0]        face_b_start;
  logic [63:0]        face_b_end;
  logic [63:0]        face_b_dir;
  logic [63:0]        contact_normal;
  logic signed [31:0] penetration;

  modport source (output valid, face_a_start, face_a_end, face_a_dir, face_b_start,
                  face_b_end, face_b_dir, contact_normal, penetration, input ready);
  modport sink (input valid, face_a_start, face_a_end, face_a_dir, face_b_start,
                face_b_end, face_b_dir, contact_normal, penetration, output ready);
endinterface

interface cmfc_out_if;
  logic               valid;
  logic               ready;
  logic [63:0]        point_first;
  logic [63:0]        point_second;
  logic [63:0]        normal_out;
  logic signed [31:0] depth_out;
  logic               contact_kind;
  logic               reference_is_b;
  logic [1:0]         fault;

  modport source (output valid, point_first, point_second, normal_out, depth_out,
                  contact_kind, reference_is_b, fault, input ready);
  modport sink (input valid, point_first, point_second, normal_out, depth_out,
                contact_kind, reference_is_b, fault, output ready);
endinterface
`default_nettype wire

>>> src/cmfc_front.sv
// Front part: takes input words and picks the reference and incident faces.
`default_nettype none
module cmfc_front import cmfc_pkg::*; #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  cmfc_in_if.sink in_i,
  output logic job_valid_o,
  output job_t job_o,
  input  logic job_full_i
);

  localparam int SHIFT = HALF_W - COMPONENT_WIDTH;

  function automatic comp_t sext(input logic [HALF_W-1:0] half);
    logic [HALF_W-1:0] up;
    up   = half << SHIFT;
    sext = $signed(up) >>> SHIFT;
  endfunction

  face_t              fa, fb;
  comp_t              cnx, cny;
  logic               s1_valid_q;
  face_t              fa_q, fb_q;
  logic [VEC_W-1:0]   normal_q;
  logic signed [31:0] depth_q;
  logic signed [63:0] pa_x_q, pa_y_q, pb_x_q, pb_y_q;
  logic signed [65:0] agree;
  logic               ref_is_b;
  logic               push;

  always_comb begin
    fa = '{sx: sext(in_i.face_a_start[63:32]), sy: sext(in_i.face_a_start[31:0]),
           ex: sext(in_i.face_a_end[63:32]),   ey: sext(in_i.face_a_end[31:0]),
           nx: sext(in_i.face_a_dir[63:32]),   ny: sext(in_i.face_a_dir[31:0])};
    fb = '{sx: sext(in_i.face_b_start[63:32]), sy: sext(in_i.face_b_start[31:0]),
           ex: sext(in_i.face_b_end[63:32]),   ey: sext(in_i.face_b_end[31:0]),
           nx: sext(in_i.face_b_dir[63:32]),   ny: sext(in_i.face_b_dir[31:0])};
    cnx = sext(in_i.contact_normal[63:32]);
    cny = sext(in_i.contact_normal[31:0]);
  end

  assign push       = s1_valid_q && !job_full_i;
  assign in_i.ready = !s1_valid_q || push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      fa_q     <= fa;
      fb_q     <= fb;
      normal_q <= in_i.contact_normal;
      depth_q  <= in_i.penetration;
      pa_x_q   <= fa.nx * cnx;
      pa_y_q   <= fa.ny * cny;
      pb_x_q   <= fb.nx * cnx;
      pb_y_q   <= fb.ny * cny;
    end
  end

  // The second face leads only when the summed agreement is negative.
  assign agree = {{2{pa_x_q[63]}}, pa_x_q} + {{2{pa_y_q[63]}}, pa_y_q}
               + {{2{pb_x_q[63]}}, pb_x_q} + {{2{pb_y_q[63]}}, pb_y_q};
  assign ref_is_b = agree[65];

  always_comb begin
    job_o.ref_f    = ref_is_b ? fb_q : fa_q;
    job_o.inc_sx   = ref_is_b ? fa_q.sx : fb_q.sx;
    job_o.inc_sy   = ref_is_b ? fa_q.sy : fb_q.sy;
    job_o.inc_ex   = ref_is_b ? fa_q.ex : fb_q.ex;
    job_o.inc_ey   = ref_is_b ? fa_q.ey : fb_q.ey;
    job_o.normal   = normal_q;
    job_o.depth    = depth_q;
    job_o.ref_is_b = ref_is_b;
  end

  assign job_valid_o = push;

endmodule
`default_nettype wire

>>> src/cmfc_fifo.sv
// Short queue of classified words between the front and back parts.
`default_nettype none
module cmfc_fifo import cmfc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

`include "contact_manifold_face_clip_macros.svh"

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `CMFC_ASSERT_IMP(a_no_overflow, push_i, !full_o, "push into a full queue")
  `CMFC_ASSERT_IMP(a_no_underflow, pop_i, valid_o, "pop from an empty queue")
  `CMFC_ASSERT_NXT(a_count_up, push_i && !pop_i, cnt_q == $past(cnt_q) + CNT_W'(1),
                   "queue count did not follow a push")

endmodule
`default_nettype wire

>>> src/cmfc_div.sv
// Pipelined restoring divider giving sixteen fraction bits of num / den.
`default_nettype none
module cmfc_div import cmfc_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [63:0]       num_i,
  input  logic [63:0]       den_i,
  output logic [FRAC_W-1:0] quo_o
);

  logic [63:0]       rem_q [DIV_STEPS];
  logic [63:0]       den_q [DIV_STEPS];
  logic [FRAC_W-1:0] quo_q [DIV_STEPS];

  // One quotient bit per stage; the result is used only when num < den.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [63:0]       rem_in, den_in;
    logic [FRAC_W-1:0] quo_in;
    logic [64:0]       shifted;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign shifted = {rem_in, 1'b0};
    assign take    = shifted >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? 64'(shifted - {1'b0, den_in}) : shifted[63:0];
        den_q[k] <= den_in;
        quo_q[k] <= {quo_in[FRAC_W-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule
`default_nettype wire

>>> src/cmfc_back.sv
// Back part: clips the incident edge, drops points in front of the reference.
`default_nettype none
module cmfc_back import cmfc_pkg::*; #(
  parameter int COMPONENT_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_valid_i,
  input  job_t job_i,
  output logic job_pop_o,
  cmfc_out_if.source out_o
);

`include "contact_manifold_face_clip_macros.svh"

  localparam int NSTG = DIV_STEPS + 8;
  localparam logic signed [33:0] OUT_MAX = (34'sd1 <<< (COMPONENT_WIDTH - 1)) - 34'sd1;
  localparam logic signed [33:0] OUT_MIN = -(34'sd1 <<< (COMPONENT_WIDTH - 1));
  localparam logic [FRAC_W:0]    T_ONE   = (FRAC_W+1)'(1) << FRAC_W;

  typedef enum logic [1:0] {
    TSEL_ZERO = 2'd0,
    TSEL_ONE  = 2'd1,
    TSEL_DIV  = 2'd2
  } tsel_e;

  typedef struct packed {
    comp_t              inc_sx;
    comp_t              inc_sy;
    comp_t              ref_sx;
    comp_t              ref_sy;
    comp_t              ref_nx;
    comp_t              ref_ny;
    comp_t              u1;
    comp_t              v1;
    logic [VEC_W-1:0]   normal;
    logic signed [31:0] depth;
    logic               ref_is_b;
    logic               zero;
  } ctx_t;

  function automatic comp_t out_sat(input comp_t base, input logic signed [49:0] prod);
    logic signed [33:0] s;
    s = {{2{base[HALF_W-1]}}, base} + $signed(prod[49:16]);
    if (s > OUT_MAX) begin
      out_sat = OUT_MAX[HALF_W-1:0];
    end else if (s < OUT_MIN) begin
      out_sat = OUT_MIN[HALF_W-1:0];
    end else begin
      out_sat = s[HALF_W-1:0];
    end
  endfunction

  function automatic logic [63:0] mag(input logic signed [64:0] v);
    logic signed [64:0] a;
    a   = v[64] ? -v : v;
    mag = a[63:0];
  endfunction

  function automatic logic [FRAC_W:0] tval(input tsel_e sel, input logic [FRAC_W-1:0] q);
    unique case (sel)
      TSEL_ZERO: tval = '0;
      TSEL_ONE:  tval = T_ONE;
      TSEL_DIV:  tval = {1'b0, q};
      default:   tval = '0;
    endcase
  endfunction

  logic            en;
  logic [NSTG-1:0] vld_q;
  logic            out_valid_q;

  ctx_t  a_ctx_q;
  comp_t a_dx1_q, a_dy1_q, a_dx2_q, a_dy2_q;
  ctx_t  b_ctx_q;
  logic signed [63:0] b_v2dx1_q, b_u2dy1_q, b_v2dx2_q, b_u2dy2_q, b_u1v2_q, b_u2v1_q;
  ctx_t  c_ctx_q;
  ctx_t  c_ctx_z;
  logic signed [64:0] c_num1_q, c_num2_q, c_den_q;
  ctx_t  d_ctx_q;
  logic [63:0] d_an1_q, d_an2_q, d_ad_q;
  logic        d_np1_q, d_np2_q;
  ctx_t  e_ctx_q  [DIV_STEPS];
  tsel_e e_sel1_q [DIV_STEPS];
  tsel_e e_sel2_q [DIV_STEPS];
  logic [FRAC_W-1:0] q1, q2;
  logic [FRAC_W:0]   t1, t2;
  ctx_t  f_ctx_q;
  logic signed [49:0] f_px1_q, f_py1_q, f_px2_q, f_py2_q;
  ctx_t  g_ctx_q;
  comp_t g_x1_q, g_y1_q, g_x2_q, g_y2_q;
  ctx_t  h_ctx_q;
  comp_t h_x1_q, h_y1_q, h_x2_q, h_y2_q;
  comp_t h_dx1_q, h_dy1_q, h_dx2_q, h_dy2_q;
  ctx_t  i_ctx_q;
  comp_t i_x1_q, i_y1_q, i_x2_q, i_y2_q;
  logic signed [63:0] i_s1a_q, i_s1b_q, i_s2a_q, i_s2b_q;
  logic signed [64:0] dot1, dot2;
  logic               out1, out2;
  tsel_e              sel1_d, sel2_d;

  // The whole back pipeline moves together whenever the output register can take a word.
  assign en        = !out_valid_q || out_o.ready;
  assign job_pop_o = en && job_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q       <= {vld_q[NSTG-2:0], job_pop_o};
      out_valid_q <= vld_q[NSTG-1];
    end
  end

  always_comb begin
    c_ctx_z      = c_ctx_q;
    c_ctx_z.zero = (c_den_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ctx_q <= '{inc_sx: job_i.inc_sx, inc_sy: job_i.inc_sy,
                   ref_sx: job_i.ref_f.sx, ref_sy: job_i.ref_f.sy,
                   ref_nx: job_i.ref_f.nx, ref_ny: job_i.ref_f.ny,
                   u1: sdiff(job_i.inc_ex, job_i.inc_sx),
                   v1: sdiff(job_i.inc_ey, job_i.inc_sy),
                   normal: job_i.normal, depth: job_i.depth,
                   ref_is_b: job_i.ref_is_b, zero: 1'b0};
      a_dx1_q <= sdiff(job_i.ref_f.sx, job_i.inc_sx);
      a_dy1_q <= sdiff(job_i.ref_f.sy, job_i.inc_sy);
      a_dx2_q <= sdiff(job_i.ref_f.ex, job_i.inc_sx);
      a_dy2_q <= sdiff(job_i.ref_f.ey, job_i.inc_sy);

      b_ctx_q   <= a_ctx_q;
      b_v2dx1_q <= a_ctx_q.ref_ny * a_dx1_q;
      b_u2dy1_q <= a_ctx_q.ref_nx * a_dy1_q;
      b_v2dx2_q <= a_ctx_q.ref_ny * a_dx2_q;
      b_u2dy2_q <= a_ctx_q.ref_nx * a_dy2_q;
      b_u1v2_q  <= a_ctx_q.u1 * a_ctx_q.ref_ny;
      b_u2v1_q  <= a_ctx_q.ref_nx * a_ctx_q.v1;

      c_ctx_q  <= b_ctx_q;
      c_num1_q <= {b_v2dx1_q[63], b_v2dx1_q} - {b_u2dy1_q[63], b_u2dy1_q};
      c_num2_q <= {b_v2dx2_q[63], b_v2dx2_q} - {b_u2dy2_q[63], b_u2dy2_q};
      c_den_q  <= {b_u1v2_q[63], b_u1v2_q} - {b_u2v1_q[63], b_u2v1_q};

      d_ctx_q      <= c_ctx_z;
      d_an1_q      <= mag(c_num1_q);
      d_an2_q      <= mag(c_num2_q);
      d_ad_q       <= mag(c_den_q);
      d_np1_q      <= (c_num1_q == '0) || (c_num1_q[64] != c_den_q[64]);
      d_np2_q      <= (c_num2_q == '0) || (c_num2_q[64] != c_den_q[64]);
    end
  end

  // A parameter of zero wins over the clamp at one, which wins over the quotient.
  always_comb begin
    priority if (d_ctx_q.zero || d_np1_q) begin
      sel1_d = TSEL_ZERO;
    end else if (d_an1_q >= d_ad_q) begin
      sel1_d = TSEL_ONE;
    end else begin
      sel1_d = TSEL_DIV;
    end
    priority if (d_ctx_q.zero || d_np2_q) begin
      sel2_d = TSEL_ZERO;
    end else if (d_an2_q >= d_ad_q) begin
      sel2_d = TSEL_ONE;
    end else begin
      sel2_d = TSEL_DIV;
    end
  end

  cmfc_div u_div1 (.clk_i(clk_i), .en_i(en), .num_i(d_an1_q), .den_i(d_ad_q), .quo_o(q1));
  cmfc_div u_div2 (.clk_i(clk_i), .en_i(en), .num_i(d_an2_q), .den_i(d_ad_q), .quo_o(q2));

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (k == 0) begin
          e_ctx_q[k]  <= d_ctx_q;
          e_sel1_q[k] <= sel1_d;
          e_sel2_q[k] <= sel2_d;
        end else begin
          e_ctx_q[k]  <= e_ctx_q[k-1];
          e_sel1_q[k] <= e_sel1_q[k-1];
          e_sel2_q[k] <= e_sel2_q[k-1];
        end
      end
    end
  end

  assign t1 = tval(e_sel1_q[DIV_STEPS-1], q1);
  assign t2 = tval(e_sel2_q[DIV_STEPS-1], q2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_ctx_q <= e_ctx_q[DIV_STEPS-1];
      f_px1_q <= $signed({1'b0, t1}) * e_ctx_q[DIV_STEPS-1].u1;
      f_py1_q <= $signed({1'b0, t1}) * e_ctx_q[DIV_STEPS-1].v1;
      f_px2_q <= $signed({1'b0, t2}) * e_ctx_q[DIV_STEPS-1].u1;
      f_py2_q <= $signed({1'b0, t2}) * e_ctx_q[DIV_STEPS-1].v1;

      g_ctx_q <= f_ctx_q;
      g_x1_q  <= out_sat(f_ctx_q.inc_sx, f_px1_q);
      g_y1_q  <= out_sat(f_ctx_q.inc_sy, f_py1_q);
      g_x2_q  <= out_sat(f_ctx_q.inc_sx, f_px2_q);
      g_y2_q  <= out_sat(f_ctx_q.inc_sy, f_py2_q);

      h_ctx_q <= g_ctx_q;
      h_x1_q  <= g_x1_q;
      h_y1_q  <= g_y1_q;
      h_x2_q  <= g_x2_q;
      h_y2_q  <= g_y2_q;
      h_dx1_q <= sdiff(g_x1_q, g_ctx_q.ref_sx);
      h_dy1_q <= sdiff(g_y1_q, g_ctx_q.ref_sy);
      h_dx2_q <= sdiff(g_x2_q, g_ctx_q.ref_sx);
      h_dy2_q <= sdiff(g_y2_q, g_ctx_q.ref_sy);

      i_ctx_q <= h_ctx_q;
      i_x1_q  <= h_x1_q;
      i_y1_q  <= h_y1_q;
      i_x2_q  <= h_x2_q;
      i_y2_q  <= h_y2_q;
      i_s1a_q <= h_dx1_q * h_ctx_q.ref_nx;
      i_s1b_q <= h_dy1_q * h_ctx_q.ref_ny;
      i_s2a_q <= h_dx2_q * h_ctx_q.ref_nx;
      i_s2b_q <= h_dy2_q * h_ctx_q.ref_ny;
    end
  end

  assign dot1 = {i_s1a_q[63], i_s1a_q} + {i_s1b_q[63], i_s1b_q};
  assign dot2 = {i_s2a_q[63], i_s2a_q} + {i_s2b_q[63], i_s2b_q};
  assign out1 = !dot1[64] && (dot1 != '0);
  assign out2 = !dot2[64] && (dot2 != '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      priority if (out1) begin
        out_o.point_first  <= {i_x2_q, i_y2_q};
        out_o.point_second <= {i_x2_q, i_y2_q};
        out_o.contact_kind <= 1'b0;
      end else if (out2) begin
        out_o.point_first  <= {i_x1_q, i_y1_q};
        out_o.point_second <= {i_x1_q, i_y1_q};
        out_o.contact_kind <= 1'b0;
      end else begin
        out_o.point_first  <= {i_x1_q, i_y1_q};
        out_o.point_second <= {i_x2_q, i_y2_q};
        out_o.contact_kind <= 1'b1;
      end
      priority if (i_ctx_q.zero) begin
        out_o.fault <= FAULT_ZERO_DIV;
      end else if (out1 && out2) begin
        out_o.fault <= FAULT_CLIPPED;
      end else begin
        out_o.fault <= FAULT_NONE;
      end
      out_o.normal_out     <= i_ctx_q.normal;
      out_o.depth_out      <= i_ctx_q.depth;
      out_o.reference_is_b <= i_ctx_q.ref_is_b;
    end
  end

  assign out_o.valid = out_valid_q;

  `CMFC_ASSERT_IMP(a_single_same, out_valid_q && !out_o.contact_kind,
                   out_o.point_first == out_o.point_second, "single contact with two points")
  `CMFC_ASSERT_IMP(a_clipped_single, out_valid_q && (out_o.fault == FAULT_CLIPPED),
                   !out_o.contact_kind, "clipped-away contact reported as a line")
  `CMFC_ASSERT_NXT(a_tail_delivers, en && vld_q[NSTG-1], out_valid_q,
                   "last pipeline stage word did not reach the output")

endmodule
`default_nettype wire

>>> src/contact_manifold_face_clip.sv
// Top level of the 2D contact manifold face clipping block.
//
//   channel | direction | word
//   --------+-----------+------------------------------------------------
//   in_i    | sink      | two faces, contact normal, penetration depth
//   out_o   | source    | two contact points, normal, depth, kind, fault
//
// One word is accepted per clock while the queue is not full. The front register,
// the queue and the back pipeline lie in turn between input and output; the
// latency is set mainly by the 16 one-bit divider stages.
// The four-entry queue lets the front keep accepting while the back stalls, until it fills.
// The back pipeline advances only when its output register is free or taken.
// Reset clears valid state only; no clearing pass is needed.
`default_nettype none
module contact_manifold_face_clip import cmfc_pkg::*; #(
  parameter int COMPONENT_WIDTH = 32
) (
  input logic clk_i,
  input logic rst_ni,
  cmfc_in_if.sink     in_i,
  cmfc_out_if.source  out_o
);

  logic job_push, job_full, job_pop, job_valid;
  job_t job_in, job_out;

  cmfc_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .job_valid_o(job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  cmfc_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_data_i(job_in),
    .full_o     (job_full),
    .pop_i      (job_pop),
    .valid_o    (job_valid),
    .data_o     (job_out)
  );

  cmfc_back #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(job_valid),
    .job_i      (job_out),
    .job_pop_o  (job_pop),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire
